### rtl/assert_macros.svh
// Assertion macros shared by the keypad scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication in same cycle");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: implication in next cycle");
`else
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/kpd_pkg.sv
// Types, constants and the key decode function of the keypad scanner.
package kpd_pkg;

  localparam int KEYS = 12;

  localparam logic [5:0] KEY_NONE = 6'd0;

  // Row-major key map: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
  localparam logic [5:0] KEY_MAP [KEYS] = '{
    6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54,
    6'd55, 6'd56, 6'd57, 6'd42, 6'd48, 6'd35
  };

  localparam logic [15:0] STABLE_TIME_RST  = 16'd22;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd100;

  localparam logic REG_STABLE_TIME  = 1'b0;
  localparam logic REG_MIN_INTERVAL = 1'b1;

  typedef struct packed {
    logic [5:0]  key_first;
    logic [5:0]  key_confirm;
    logic [31:0] now_ms;
  } item_t;

  // ASCII of the only pressed key, KEY_NONE for no key or several keys.
  function automatic logic [5:0] decode_snapshot(input logic [KEYS-1:0] s);
    logic [5:0] code;
    code = KEY_NONE;
    for (int i = 0; i < KEYS; i++) begin
      if (s == (KEYS'(1) << i)) begin
        code = KEY_MAP[i];
      end
    end
    return code;
  endfunction

endpackage

### rtl/kpd_fifo.sv
// Small register queue used between front and back and at the result side.
`include "assert_macros.svh"

module kpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  `ASSERT_NEVER(a_no_write_when_full, clk, rst, wr_en && full)
  `ASSERT_NEVER(a_no_read_when_empty, clk, rst, rd_en && empty)
  `ASSERT_NEVER(a_count_in_range, clk, rst, count > CW'(DEPTH))

endmodule

### rtl/kpd_front.sv
// Front end: takes a poll beat and decodes both snapshots into key codes.
module kpd_front (
  input  logic              push,
  output logic              full,
  input  logic [11:0]       scan_first,
  input  logic [11:0]       scan_confirm,
  input  logic [31:0]       now_ms,
  input  logic              q_full,
  output logic              q_wr,
  output kpd_pkg::item_t    q_item
);

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_item.key_first   = kpd_pkg::decode_snapshot(scan_first);
    q_item.key_confirm = kpd_pkg::decode_snapshot(scan_confirm);
    q_item.now_ms      = now_ms;
  end

endmodule

### rtl/kpd_back.sv
// Back end: debounce state, timing checks and configuration registers.
`include "assert_macros.svh"

module kpd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wen,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           q_empty,
  input  kpd_pkg::item_t q_item,
  output logic           q_rd,
  input  logic           res_full,
  output logic           res_wr,
  output logic [5:0]     res_code
);

  logic [15:0] stable_time;
  logic [15:0] min_interval;

  logic        await_release, await_release_next;
  logic [5:0]  candidate_key, candidate_key_next;
  logic [31:0] stable_start, stable_start_next;
  logic [31:0] last_emit, last_emit_next;

  logic [31:0] stable_elapsed;
  logic [31:0] emit_elapsed;
  logic        stable_short;
  logic        interval_short;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_time  <= kpd_pkg::STABLE_TIME_RST;
      min_interval <= kpd_pkg::MIN_INTERVAL_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        kpd_pkg::REG_STABLE_TIME:  stable_time  <= cfg_data;
        kpd_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign q_rd   = !q_empty && !res_full;
  assign res_wr = q_rd;

  assign stable_elapsed = q_item.now_ms - stable_start;
  assign emit_elapsed   = q_item.now_ms - last_emit;
  assign stable_short   = stable_elapsed < {16'd0, stable_time};
  assign interval_short = (last_emit != '0) && (emit_elapsed < {16'd0, min_interval});

  always_comb begin
    await_release_next = await_release;
    candidate_key_next = candidate_key;
    stable_start_next  = stable_start;
    last_emit_next     = last_emit;
    res_code           = kpd_pkg::KEY_NONE;
    if (await_release) begin
      if (q_item.key_first == kpd_pkg::KEY_NONE) begin
        await_release_next = 1'b0;
        candidate_key_next = kpd_pkg::KEY_NONE;
        stable_start_next  = '0;
      end
    end else if (q_item.key_first == kpd_pkg::KEY_NONE) begin
      candidate_key_next = kpd_pkg::KEY_NONE;
      stable_start_next  = '0;
    end else if (q_item.key_first != candidate_key) begin
      candidate_key_next = q_item.key_first;
      stable_start_next  = q_item.now_ms;
    end else if (stable_short || interval_short) begin
      // still settling or too soon after the last emit
    end else if (q_item.key_confirm != q_item.key_first) begin
      candidate_key_next = kpd_pkg::KEY_NONE;
      stable_start_next  = '0;
    end else begin
      last_emit_next     = q_item.now_ms;
      await_release_next = 1'b1;
      candidate_key_next = kpd_pkg::KEY_NONE;
      stable_start_next  = '0;
      res_code           = q_item.key_first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      await_release <= 1'b0;
      candidate_key <= kpd_pkg::KEY_NONE;
      stable_start  <= '0;
      last_emit     <= '0;
    end else if (q_rd) begin
      await_release <= await_release_next;
      candidate_key <= candidate_key_next;
      stable_start  <= stable_start_next;
      last_emit     <= last_emit_next;
    end
  end

  `ASSERT_NEVER(a_no_candidate_while_waiting, clk, rst,
                await_release && (candidate_key != kpd_pkg::KEY_NONE))
  `ASSERT_IMPLIES(a_start_clear_without_candidate, clk, rst,
                  candidate_key == kpd_pkg::KEY_NONE, stable_start == '0)
  `ASSERT_NEXT(a_emit_arms_release, clk, rst,
               res_wr && (res_code != kpd_pkg::KEY_NONE), await_release)

endmodule

### rtl/keypad_scan_debounce.sv
// Top level of the debounced 4x3 keypad scanner.
// Each poll beat (two 12-bit snapshots and a millisecond tick) yields exactly one
// result beat: the ASCII code of a debounced key, or zero. The front decodes both
// snapshots, a queue of QUEUE_DEPTH entries hands the poll to the back, which holds
// the debounce state and the two 32-bit elapsed-time compares, and a result queue of
// the same depth holds answers until popped. One poll is taken per cycle while full
// is low. A poll's result goes through the item queue, the back and the result queue
// before it can be popped. While the result queue is full the back stalls, and full
// rises once the item queue has filled as well. Registers:
// index 0 stable_time_ms (reset 22), index 1 min_interval_ms (reset 100).
module keypad_scan_debounce #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [11:0] scan_first,
  input  logic [11:0] scan_confirm,
  input  logic [31:0] now_ms,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  key_code,
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ITEM_W = $bits(kpd_pkg::item_t);

  kpd_pkg::item_t fq_wr_item;
  kpd_pkg::item_t fq_rd_item;
  logic           fq_wr, fq_full, fq_rd, fq_empty;
  logic           res_wr, res_full;
  logic [5:0]     res_code;

  kpd_front u_front (
    .push         (push),
    .full         (full),
    .scan_first   (scan_first),
    .scan_confirm (scan_confirm),
    .now_ms       (now_ms),
    .q_full       (fq_full),
    .q_wr         (fq_wr),
    .q_item       (fq_wr_item)
  );

  kpd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_wr),
    .wr_data (fq_wr_item),
    .full    (fq_full),
    .rd_en   (fq_rd),
    .rd_data (fq_rd_item),
    .empty   (fq_empty)
  );

  kpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (fq_empty),
    .q_item    (fq_rd_item),
    .q_rd      (fq_rd),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res_code  (res_code)
  );

  kpd_fifo #(
    .WIDTH (6),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_code),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .rd_data (key_code),
    .empty   (empty)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the debounced 4x3 keypad scanner.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_POLLS    = 185;
  localparam int LONG_HOLD      = 80;

  localparam logic [5:0] PAD_CHARS [12] = '{
    6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54,
    6'd55, 6'd56, 6'd57, 6'd42, 6'd48, 6'd35
  };

  typedef struct {
    logic [11:0] scan_a;
    logic [11:0] scan_b;
    logic [31:0] tick;
    bit          fixed;
    logic [5:0]  code;
  } poll_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [11:0] scan_first = '0;
  logic [11:0] scan_confirm = '0;
  logic [31:0] now_ms = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [5:0]  key_code;
  logic        cfg_wen = 1'b0;
  logic        cfg_index = kpd_pkg::REG_STABLE_TIME;
  logic [15:0] cfg_data = '0;

  // debounce state mirror
  bit          await_rel = 1'b0;
  logic [5:0]  cand_key = kpd_pkg::KEY_NONE;
  logic [31:0] press_start = '0;
  logic [31:0] last_emit = '0;
  logic [15:0] stable_ms = kpd_pkg::STABLE_TIME_RST;
  logic [15:0] interval_ms = kpd_pkg::MIN_INTERVAL_RST;

  logic [5:0]  key_q [$];
  int          err_count = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] tick_now = '0;
  logic [5:0]  want;
  poll_row_t   dir_rows [$];

  keypad_scan_debounce u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .scan_first   (scan_first),
    .scan_confirm (scan_confirm),
    .now_ms       (now_ms),
    .empty        (empty),
    .pop          (pop),
    .key_code     (key_code),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [5:0] key_of(input logic [11:0] s);
    logic [5:0] ch;
    ch = kpd_pkg::KEY_NONE;
    if ($countones(s) == 1) begin
      for (int i = 0; i < 12; i++) begin
        if (s[i]) begin
          ch = PAD_CHARS[i];
        end
      end
    end
    return ch;
  endfunction

  function automatic logic [5:0] debounce_poll(input logic [11:0] sa, input logic [11:0] sb,
                                               input logic [31:0] t);
    logic [5:0]  ch;
    logic [31:0] held;
    logic [31:0] since;
    ch = key_of(sa);
    held = t - press_start;
    since = t - last_emit;
    if (await_rel) begin
      if (ch == kpd_pkg::KEY_NONE) begin
        await_rel = 1'b0;
        cand_key = kpd_pkg::KEY_NONE;
        press_start = '0;
      end
      return kpd_pkg::KEY_NONE;
    end
    if (ch == kpd_pkg::KEY_NONE) begin
      cand_key = kpd_pkg::KEY_NONE;
      press_start = '0;
      return kpd_pkg::KEY_NONE;
    end
    if (ch != cand_key) begin
      cand_key = ch;
      press_start = t;
      return kpd_pkg::KEY_NONE;
    end
    if (held < {16'd0, stable_ms}) return kpd_pkg::KEY_NONE;
    if (last_emit != '0 && since < {16'd0, interval_ms}) return kpd_pkg::KEY_NONE;
    if (key_of(sb) != ch) begin
      cand_key = kpd_pkg::KEY_NONE;
      press_start = '0;
      return kpd_pkg::KEY_NONE;
    end
    last_emit = t;
    await_rel = 1'b1;
    cand_key = kpd_pkg::KEY_NONE;
    press_start = '0;
    return ch;
  endfunction

  task automatic report_mismatch(input string what, input logic [5:0] got,
                                 input logic [5:0] exp_code);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, exp_code, $realtime);
    err_count++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == kpd_pkg::REG_STABLE_TIME) stable_ms = val;
    else interval_ms = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (key_q.size() != 0) @(posedge clk);
  endtask

  // offer one poll beat, wait for it to be taken, then maybe leave a gap
  task automatic send_poll(input logic [11:0] sa, input logic [11:0] sb, input logic [31:0] t,
                           input bit fixed, input logic [5:0] code);
    logic [5:0] pred;
    push <= 1'b1;
    scan_first <= sa;
    scan_confirm <= sb;
    now_ms <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    pred = debounce_poll(sa, sb, t);
    key_q.push_back(fixed ? code : pred);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic run_random(input int count);
    int          done;
    int          n;
    int          k;
    logic [11:0] kb;
    logic [11:0] sb;
    logic [11:0] sa;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 11);
        kb = 12'(1) << k;
        n = $urandom_range(1, 5);
        tick_now += $urandom_range(0, int'(interval_ms) + 10);
        for (int i = 0; i < n; i++) begin
          sa = ($urandom_range(0, 11) == 0) ? 12'(1) << $urandom_range(0, 11) : kb;
          sb = ($urandom_range(0, 7) == 0) ? 12'($urandom) : sa;
          send_poll(sa, sb, tick_now, 1'b0, kpd_pkg::KEY_NONE);
          tick_now += $urandom_range(0, int'(stable_ms) / 2 + 4);
          done++;
        end
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) begin
          sa = ($urandom_range(0, 3) == 0) ?
               kb | (12'(1) << ((k + 1 + $urandom_range(0, 10)) % 12)) : 12'h000;
          send_poll(sa, 12'($urandom), tick_now, 1'b0, kpd_pkg::KEY_NONE);
          tick_now += $urandom_range(0, 8);
          done++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: tick_now = $urandom;
          1: tick_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
          2: tick_now = '0;
          default: tick_now += $urandom_range(0, 50);
        endcase
        sa = $urandom_range(0, 1) ? 12'($urandom) : 12'(1) << $urandom_range(0, 11);
        send_poll(sa, 12'($urandom), tick_now, 1'b0, kpd_pkg::KEY_NONE);
        done++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (key_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", key_code, kpd_pkg::KEY_NONE);
        end else begin
          want = key_q.pop_front();
          if (key_code !== want) report_mismatch("key_code", key_code, want);
        end
      end
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_wen) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    // special cases under reset settings (22 ms stable, 100 ms interval)
    dir_rows.push_back('{12'h000, 12'h000, 32'd0, 1'b1, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'hFFF, 12'hFFF, 32'd5, 1'b1, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h003, 12'h003, 32'd6, 1'b1, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h009, 12'h009, 32'd7, 1'b1, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h001, 12'h001, 32'd1000, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h001, 12'h001, 32'd1010, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h001, 12'h002, 32'd1030, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h001, 12'h001, 32'd1031, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h001, 12'h001, 32'd1053, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h001, 12'h001, 32'd2000, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h010, 12'h010, 32'd2001, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h000, 12'h000, 32'd2002, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h010, 12'h010, 32'd1060, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h010, 12'h010, 32'd1100, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h010, 12'h010, 32'd1153, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h000, 12'hFFF, 32'd1154, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h800, 12'h800, 32'hFFFF_FFD0, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h200, 12'h200, 32'hFFFF_FFE0, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h200, 12'h200, 32'h0000_0000, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h000, 12'h000, 32'd1, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h400, 12'h400, 32'd2, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h400, 12'h400, 32'd24, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h000, 12'h000, 32'd25, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h800, 12'h800, 32'd100, 1'b0, kpd_pkg::KEY_NONE});
    dir_rows.push_back('{12'h800, 12'h800, 32'd230, 1'b0, kpd_pkg::KEY_NONE});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_poll(dir_rows[i].scan_a, dir_rows[i].scan_b, dir_rows[i].tick,
                dir_rows[i].fixed, dir_rows[i].code);
    end

    for (int ph = 0; ph < 5; ph++) begin
      push <= 1'b0;
      wait_drained();
      case (ph)
        0: begin
          write_reg(kpd_pkg::REG_STABLE_TIME, 16'd0);
          write_reg(kpd_pkg::REG_MIN_INTERVAL, 16'd0);
        end
        1: begin
          write_reg(kpd_pkg::REG_STABLE_TIME, 16'hFFFF);
          write_reg(kpd_pkg::REG_MIN_INTERVAL, 16'hFFFF);
        end
        2: begin
          write_reg(kpd_pkg::REG_STABLE_TIME, 16'd5);
          write_reg(kpd_pkg::REG_MIN_INTERVAL, 16'd20);
        end
        3: begin
          write_reg(kpd_pkg::REG_STABLE_TIME, 16'($urandom_range(0, 300)));
          write_reg(kpd_pkg::REG_MIN_INTERVAL, 16'($urandom));
        end
        default: begin
          write_reg(kpd_pkg::REG_STABLE_TIME, kpd_pkg::STABLE_TIME_RST);
          write_reg(kpd_pkg::REG_MIN_INTERVAL, kpd_pkg::MIN_INTERVAL_RST);
          idle_on = 1'b0;
        end
      endcase
      cfg_wen <= 1'b0;
      tick_now = $urandom;
      if (ph == 0) hold_req = 1'b1;
      run_random(PHASE_POLLS);
    end

    push <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
